### sv/sha1sh_pkg.sv
// Package for the streaming SHA-1 hasher: beat types, operation codes and
// round/initial constants. No dependencies.
package sha1sh_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam int NUM_WORDS = 5;
  localparam int NUM_ROUNDS = 80;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

endpackage

### sv/sha1_stream_hasher.sv
// Streaming SHA-1 hasher top level: byte absorb, padding, round unit, digest out.
// Depends on sha1sh_pkg.
//
// Absorb beats are taken one byte per cycle while idle; the 64th byte of a block
// starts the compression, which runs all 80 rounds on one shared round datapath
// and then adds the chaining words, and input is stalled until it is done.
// A finish beat shifts padding bytes into the block buffer one per cycle (up
// to 64 when a second block is needed), shifts in the 8 length bytes, runs one
// or two compressions and then presents the five digest words on the output
// register, one per cycle as the sink takes them. The next message may start
// as soon as the last digest word is loaded.
module sha1_stream_hasher
  import sha1sh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t       state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  count_r, count_nxt;
  logic [63:0]  len_r, len_nxt;
  logic         first_r, first_nxt;
  logic         fin_r, fin_nxt;
  logic         len_done_r, len_done_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [31:0]  h_r [NUM_WORDS];
  logic [31:0]  h_nxt [NUM_WORDS];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_t         out_r, out_nxt;

  logic [31:0]  f_w, k_w, t_w, w0, sched_w, sched_x;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign w0      = buf_r[511:480];
  assign sched_x = buf_r[95:64] ^ buf_r[255:224] ^ buf_r[447:416] ^ w0;
  assign sched_w = {sched_x[30:0], sched_x[31]};

  always_comb begin
    priority if (rnd_r < 7'd20) begin
      f_w = (b_r & c_r) | (~b_r & d_r);
      k_w = K0;
    end else if (rnd_r < 7'd40) begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = K1;
    end else if (rnd_r < 7'd60) begin
      f_w = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_w = K2;
    end else begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = K3;
    end
  end

  assign t_w = {a_r[26:0], a_r[31:27]} + f_w + e_r + k_w + w0;

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    fin_nxt       = fin_r;
    len_done_nxt  = len_done_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_ABSORB) begin
            buf_nxt   = {buf_r[503:0], in_data.data_byte};
            count_nxt = count_r + 61'd1;
            fill_nxt  = fill_r + 6'd1;
            fin_nxt   = 1'b0;
            if (fill_r == 6'd63) begin
              state_nxt = ST_RND;
            end
          end else begin
            len_nxt      = {count_r, 3'b000};
            first_nxt    = 1'b1;
            fin_nxt      = 1'b1;
            len_done_nxt = 1'b0;
            state_nxt    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == 6'd56 && !first_r) begin
          state_nxt = ST_LEN;
        end else begin
          buf_nxt   = {buf_r[503:0], (first_r ? PAD_MARK : 8'h00)};
          first_nxt = 1'b0;
          fill_nxt  = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            state_nxt = ST_RND;
          end
        end
      end
      ST_LEN: begin
        buf_nxt  = {buf_r[503:0], len_r[63:56]};
        len_nxt  = {len_r[55:0], 8'h00};
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          len_done_nxt = 1'b1;
          state_nxt    = ST_RND;
        end
      end
      ST_RND: begin
        a_nxt   = t_w;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        buf_nxt = {buf_r[479:0], sched_w};
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        idx_nxt  = 3'd0;
        priority if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_done_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.digest_word = h_r[idx_r];
          out_nxt.word_index  = idx_r;
          out_nxt.last_word   = (idx_r == 3'(NUM_WORDS - 1));
          idx_nxt             = idx_r + 3'd1;
          if (idx_r == 3'(NUM_WORDS - 1)) begin
            h_nxt[0]  = H0_INIT;
            h_nxt[1]  = H1_INIT;
            h_nxt[2]  = H2_INIT;
            h_nxt[3]  = H3_INIT;
            h_nxt[4]  = H4_INIT;
            count_nxt = '0;
            fill_nxt  = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // load the working variables when a compression starts
    if (state_nxt == ST_RND && state_r != ST_RND) begin
      a_nxt   = h_r[0];
      b_nxt   = h_r[1];
      c_nxt   = h_r[2];
      d_nxt   = h_r[3];
      e_nxt   = h_r[4];
      rnd_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      first_r     <= 1'b0;
      fin_r       <= 1'b0;
      len_done_r  <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      h_r[0]      <= H0_INIT;
      h_r[1]      <= H1_INIT;
      h_r[2]      <= H2_INIT;
      h_r[3]      <= H3_INIT;
      h_r[4]      <= H4_INIT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      fin_r       <= fin_nxt;
      len_done_r  <= len_done_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
    buf_r <= buf_nxt;
    len_r <= len_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    out_r <= out_nxt;
  end

endmodule

### tb/tb_sha1_stream_hasher.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha1_stream_hasher: streams byte and finish beats,
// predicts each digest with a behavioral SHA-1 and checks every digest word.
// Depends on sha1sh_pkg and the sha1_stream_hasher RTL.
module tb_sha1_stream_hasher
  import sha1sh_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam int BLOCK_LEN = 64;
  localparam int LEN_POS = 56;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int sender_idle_pct = 0;
  int sink_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  logic [31:0] chain_h [NUM_WORDS];
  logic [7:0]  block_buf [BLOCK_LEN];
  int          fill_level;
  logic [60:0] msg_bytes;
  out_t        digest_q [$];

  sha1_stream_hasher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void chain_reset();
    chain_h[0] = H0_INIT;
    chain_h[1] = H1_INIT;
    chain_h[2] = H2_INIT;
    chain_h[3] = H3_INIT;
    chain_h[4] = H4_INIT;
    fill_level = 0;
    msg_bytes = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [NUM_ROUNDS];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    end
    for (int r = 16; r < NUM_ROUNDS; r++) begin
      w[r] = rotl32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void predict_beat(input in_t beat);
    logic [63:0] bit_len;
    out_t        word;
    if (beat.operation == OP_ABSORB) begin
      block_buf[fill_level] = beat.data_byte;
      fill_level++;
      msg_bytes++;
      if (fill_level == BLOCK_LEN) begin
        sha1_compress();
        fill_level = 0;
      end
    end else begin
      block_buf[fill_level] = PAD_MARK;
      for (int i = fill_level + 1; i < BLOCK_LEN; i++) block_buf[i] = 8'h00;
      // no room for the length: flush this block, length goes in a zero block
      if (fill_level >= LEN_POS) begin
        sha1_compress();
        for (int i = 0; i < BLOCK_LEN; i++) block_buf[i] = 8'h00;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
      sha1_compress();
      for (int i = 0; i < NUM_WORDS; i++) begin
        word.digest_word = chain_h[i];
        word.word_index = 3'(i);
        word.last_word = (i == NUM_WORDS - 1);
        digest_q.push_back(word);
      end
      chain_reset();
    end
  endfunction

  task automatic send_beat(input logic op, input logic [7:0] value);
    in_t beat;
    beat.operation = op;
    beat.data_byte = value;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(beat);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_beat(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    send_beat(OP_FINISH, 8'h00);
    send_beat(OP_FINISH, 8'hff);
    send_beat(OP_ABSORB, 8'h61);
    send_beat(OP_ABSORB, 8'h62);
    send_beat(OP_ABSORB, 8'h63);
    send_beat(OP_FINISH, 8'h5a);
    send_beat(OP_ABSORB, 8'h00);
    send_beat(OP_ABSORB, 8'hff);
    send_beat(OP_ABSORB, 8'h80);
    send_beat(OP_ABSORB, 8'h7f);
    send_beat(OP_FINISH, 8'h00);
  endtask

  // 56 bytes forces the extra length block; 64 fills a block before padding
  task automatic test_block_edges();
    send_message(LEN_POS);
    send_message(BLOCK_LEN);
  endtask

  task automatic test_random_messages(input int count);
    int len;
    for (int m = 0; m < count; m++) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 8);
      send_message(len);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected digest beat: word %h index %0d last %b",
                     out_data.digest_word, out_data.word_index, out_data.last_word);
          error_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word ||
              out_data.word_index !== want.word_index ||
              out_data.last_word !== want.last_word) begin
            if (error_count < MAX_REPORTS)
              $display({"digest mismatch: exp word %h index %0d last %b, ",
                        "got word %h index %0d last %b"},
                       want.digest_word, want.word_index, want.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sha1_stream_hasher: errors");
      $finish;
    end
  end

  initial begin
    chain_reset();
    sender_idle_pct = 32;
    sink_idle_pct = 64;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_block_edges();
    sender_idle_pct = 64;
    sink_idle_pct = 32;
    test_random_messages(4);
    sender_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_messages(4);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && digest_q.size() == 0) begin
      $display("tb_sha1_stream_hasher: clean");
    end else begin
      $display("tb_sha1_stream_hasher: errors");
    end
    $finish;
  end

endmodule
